// ----- rtl/core/tel_pkg.sv -----
// Shared types and constants for the throttled event log writer.
`timescale 1ns / 1ps

package tel_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int LOG_SLOTS_MAX = 1024;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOT_W  = 10;
   localparam int CAP_W   = 11;
   localparam int COUNT_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0]      END_CODE  = 16'hFFFF;
   localparam logic [31:0]      END_TIME  = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [15:0]      RST_ERROR_CODE_START = 16'd32768;
   localparam logic [15:0]      RST_MARKER_CODE      = 16'd0;
   localparam logic [7:0]       RST_PER_CODE_LIMIT   = 8'd20;
   localparam logic [CAP_W-1:0] RST_LOG_CAPACITY     = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERROR_CODE_START,
      CSR_THROTTLE_MARKER_CODE,
      CSR_PER_CODE_LIMIT,
      CSR_LOG_CAPACITY
   } csr_index_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_MARKER,
      EMIT_EVENT,
      EMIT_END
   } emit_kind_type;

   typedef struct packed {
      logic [15:0] event_code;
      logic [31:0] event_time;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic [15:0]       record_code;
      logic [31:0]       record_time;
      logic              is_end_marker;
      logic [31:0]       error_total;
      logic              last_write;
   } rsp_type;

   typedef struct packed {
      logic          capture;
      logic          lookup;
      logic          update;
      emit_kind_type emit;
      logic          last;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic marker;
      logic out_ready;
   } sts_type;

endpackage

// ----- rtl/core/throttled_event_log_writer.sv -----
// Throttled event log writer: top level joining controller and datapath.
//
// Input channel req_*: one event (code, timestamp) per transfer. Result
// channel rsp_*: one ring slot write per transfer, two or four per logged
// event (optional throttle marker plus its end marker, then the event record
// plus its end marker); a dropped event yields none. last_write flags the
// final write of an event. The csr_* port writes the four registers by
// index. Use it only while the block is idle; the block does not enforce it.
// Timing: after a transfer the block does the parallel table compare, then
// the count update, then the slot writes one after another; a dropped event
// ends after the update. req_stall stays high until the event is done; the
// single result register sets the pace of the writes. A stall on rsp_* holds
// the result register and the controller waits; the next event is taken once
// the last write is loaded.
// Reset (synchronous, active high) restores register defaults, clears the
// table fill count, the write slot and the error counter; table contents
// need no clearing because only filled entries are compared.
`timescale 1ns / 1ps

module throttled_event_log_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tel_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tel_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tel_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tel_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tel_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Busy right after taking an event
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while previous event still in progress");

   // A pending non-final write means the event is not finished
   a_busy_mid_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_write) |-> req_stall)
      else $error("block idle with an event's writes outstanding");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_write) |-> rsp_data.is_end_marker)
      else $error("final write of an event is not an end marker");

   a_end_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_end_marker) |->
         (rsp_data.record_code == END_CODE && rsp_data.record_time == END_TIME))
      else $error("end marker write carries wrong code or time");

endmodule

// ----- rtl/core/tel_dpath.sv -----
// Datapath: config registers, code table, counters, ring slot and result register.
`timescale 1ns / 1ps

module tel_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  tel_pkg::req_type               req_data,
   input  logic                           csr_we,
   input  logic [tel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tel_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  tel_pkg::cmd_type               cmd,
   output tel_pkg::sts_type               sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tel_pkg::rsp_type               rsp_data
);
   import tel_pkg::*;

   logic [15:0]        err_start_ff;
   logic [15:0]        marker_code_ff;
   logic [7:0]         limit_ff;
   logic [CAP_W-1:0]   capacity_ff;
   logic [15:0]        code_ff;
   logic [31:0]        time_ff;
   logic [31:0]        error_ff, error_in;
   logic [15:0]        seen_codes_ff  [TABLE_ENTRIES];
   logic [COUNT_W-1:0] seen_counts_ff [TABLE_ENTRIES];
   logic [USED_W-1:0]  used_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [COUNT_W-1:0]       cur_count, new_count;
   logic [CAP_W-1:0]         cap_eff;
   logic [SLOT_W-1:0]        slot_cur, slot_nxt;
   logic [CAP_W-1:0]         slot_inc;
   logic                     out_ready, load_rsp, table_open;

   // Parallel compare against the occupied part of the table
   always_comb begin
      hit_idx_in = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = (USED_W'(i) < used_ff) && (seen_codes_ff[i] == code_ff);
         if (hit_vec[i]) hit_idx_in = hit_idx_in | IDX_W'(i);
      end
   end

   assign cur_count  = seen_counts_ff[hit_idx_ff];
   assign new_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
   assign table_open = used_ff < USED_W'(TABLE_ENTRIES);

   assign error_in = ((req_data.event_code >= err_start_ff) && (error_ff != '1))
                     ? error_ff + 32'd1 : error_ff;

   // Effective ring size and the wrap of the write slot
   always_comb begin
      if (capacity_ff == '0)                          cap_eff = CAP_W'(1);
      else if (capacity_ff > CAP_W'(LOG_SLOTS_MAX))   cap_eff = CAP_W'(LOG_SLOTS_MAX);
      else                                            cap_eff = capacity_ff;
      slot_cur = ({1'b0, slot_ff} >= cap_eff) ? '0 : slot_ff;
      slot_inc = {1'b0, slot_cur} + CAP_W'(1);
      slot_nxt = (slot_inc >= cap_eff) ? '0 : slot_inc[SLOT_W-1:0];
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = cmd.emit != EMIT_NONE;

   always_comb begin
      rsp_in.slot_index    = slot_cur;
      rsp_in.record_code   = code_ff;
      rsp_in.record_time   = time_ff;
      rsp_in.is_end_marker = 1'b0;
      rsp_in.error_total   = error_ff;
      rsp_in.last_write    = cmd.last;
      case (cmd.emit)
         EMIT_MARKER: rsp_in.record_code = marker_code_ff;
         EMIT_EVENT:  rsp_in.record_code = code_ff;
         EMIT_END: begin
            rsp_in.slot_index    = slot_ff;
            rsp_in.record_code   = END_CODE;
            rsp_in.record_time   = END_TIME;
            rsp_in.is_end_marker = 1'b1;
         end
         default: rsp_in.record_code = code_ff;
      endcase
   end

   always_comb begin
      sts.drop      = hit_ff && (new_count > {1'b0, limit_ff});
      sts.marker    = hit_ff && (new_count == {1'b0, limit_ff});
      sts.out_ready = out_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_start_ff   <= RST_ERROR_CODE_START;
         marker_code_ff <= RST_MARKER_CODE;
         limit_ff       <= RST_PER_CODE_LIMIT;
         capacity_ff    <= RST_LOG_CAPACITY;
         error_ff       <= '0;
         used_ff        <= '0;
         slot_ff        <= '0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ERROR_CODE_START:     err_start_ff   <= csr_wdata;
               CSR_THROTTLE_MARKER_CODE: marker_code_ff <= csr_wdata;
               CSR_PER_CODE_LIMIT:       limit_ff       <= csr_wdata[7:0];
               CSR_LOG_CAPACITY:         capacity_ff    <= csr_wdata[CAP_W-1:0];
               default:                  limit_ff       <= limit_ff;
            endcase
         end
         if (cmd.capture) error_ff <= error_in;
         if (cmd.lookup) hit_ff <= |hit_vec;
         if (cmd.update && !hit_ff && table_open) used_ff <= used_ff + 1'b1;
         // advance the ring only on a record write; the end marker lands on the new slot
         if (load_rsp && (cmd.emit != EMIT_END)) slot_ff <= slot_nxt;
         if (load_rsp)                rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_data.event_code;
         time_ff <= req_data.event_time;
      end
      if (cmd.lookup) hit_idx_ff <= hit_idx_in;
      if (cmd.update) begin
         if (hit_ff) begin
            seen_counts_ff[hit_idx_ff] <= new_count;
         end else if (table_open) begin
            seen_codes_ff[used_ff[IDX_W-1:0]]  <= code_ff;
            seen_counts_ff[used_ff[IDX_W-1:0]] <= COUNT_W'(1);
         end
      end
      if (load_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/tel_ctrl.sv -----
// Controller: sequences lookup, table update and the record writes of one event.
`timescale 1ns / 1ps

module tel_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output tel_pkg::cmd_type cmd,
   input  tel_pkg::sts_type sts
);
   import tel_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_MARK,
      ST_MARK_END,
      ST_EVENT,
      ST_EVENT_END
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.emit    = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.drop)        state_in = ST_IDLE;
            else if (sts.marker) state_in = ST_MARK;
            else                 state_in = ST_EVENT;
         end
         ST_MARK: if (sts.out_ready) begin
            cmd.emit = EMIT_MARKER;
            state_in = ST_MARK_END;
         end
         ST_MARK_END: if (sts.out_ready) begin
            cmd.emit = EMIT_END;
            state_in = ST_EVENT;
         end
         ST_EVENT: if (sts.out_ready) begin
            cmd.emit = EMIT_EVENT;
            state_in = ST_EVENT_END;
         end
         ST_EVENT_END: if (sts.out_ready) begin
            cmd.emit = EMIT_END;
            cmd.last = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      stall_in = state_in != ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the throttled event log writer: directed and random events checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
   import tel_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOT_CODES   = 8;

   class tel_scoreboard;
      logic [15:0]        err_start;
      logic [15:0]        marker_code;
      logic [7:0]         code_limit;
      logic [CAP_W-1:0]   capacity;
      logic [15:0]        seen_code [TABLE_ENTRIES];
      logic [COUNT_W-1:0] seen_count [TABLE_ENTRIES];
      int                 filled;
      logic [SLOT_W-1:0]  next_slot;
      logic [31:0]        error_count;
      rsp_type            pending_writes [$];
      int                 failures;
      int                 events_noted;
      int                 writes_checked;
      int                 markers_predicted;
      int                 events_dropped;

      function new();
         err_start         = RST_ERROR_CODE_START;
         marker_code       = RST_MARKER_CODE;
         code_limit        = RST_PER_CODE_LIMIT;
         capacity          = RST_LOG_CAPACITY;
         filled            = 0;
         next_slot         = '0;
         error_count       = '0;
         failures          = 0;
         events_noted      = 0;
         writes_checked    = 0;
         markers_predicted = 0;
         events_dropped    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ERROR_CODE_START:     err_start   = value[15:0];
            CSR_THROTTLE_MARKER_CODE: marker_code = value[15:0];
            CSR_PER_CODE_LIMIT:       code_limit  = value[7:0];
            CSR_LOG_CAPACITY:         capacity    = value[CAP_W-1:0];
            default: ;
         endcase
      endfunction

      // Clamp the programmed capacity into 1..LOG_SLOTS_MAX.
      function int ring_size();
         int size_now;
         size_now = int'(capacity);
         if (size_now == 0) size_now = 1;
         if (size_now > LOG_SLOTS_MAX) size_now = LOG_SLOTS_MAX;
         return size_now;
      endfunction

      // Queue one record write and the end marker in the slot after it.
      function void queue_record(logic [15:0] code, logic [31:0] stamp, bit closes_event);
         rsp_type wr;
         int      slot_now;
         slot_now = int'(next_slot);
         if (slot_now >= ring_size()) slot_now = 0;
         wr.slot_index    = slot_now[SLOT_W-1:0];
         wr.record_code   = code;
         wr.record_time   = stamp;
         wr.is_end_marker = 1'b0;
         wr.error_total   = error_count;
         wr.last_write    = 1'b0;
         pending_writes.push_back(wr);
         slot_now++;
         if (slot_now >= ring_size()) slot_now = 0;
         next_slot        = slot_now[SLOT_W-1:0];
         wr.slot_index    = slot_now[SLOT_W-1:0];
         wr.record_code   = END_CODE;
         wr.record_time   = END_TIME;
         wr.is_end_marker = 1'b1;
         wr.last_write    = closes_event;
         pending_writes.push_back(wr);
      endfunction

      function void note_event(req_type ev);
         int hit;
         int bumped;
         hit = -1;
         events_noted++;
         if (ev.event_code >= err_start && error_count != END_TIME) error_count++;
         for (int i = 0; i < filled; i++) begin
            if (hit < 0 && seen_code[i] == ev.event_code) hit = i;
         end
         if (hit >= 0) begin
            bumped = int'(seen_count[hit]);
            if (bumped < COUNT_MAX) bumped++;
            seen_count[hit] = bumped[COUNT_W-1:0];
            if (bumped > code_limit) begin
               events_dropped++;
               return;
            end
            if (bumped == code_limit) begin
               markers_predicted++;
               queue_record(marker_code, ev.event_time, 1'b0);
            end
         end else if (filled < TABLE_ENTRIES) begin
            seen_code[filled]  = ev.event_code;
            seen_count[filled] = COUNT_W'(1);
            filled++;
         end
         queue_record(ev.event_code, ev.event_time, 1'b1);
      endfunction

      function void check_write(rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            $error("unexpected slot write: slot %0d code %h", got.slot_index, got.record_code);
            failures++;
            return;
         end
         want = pending_writes.pop_front();
         writes_checked++;
         if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            failures++;
         end
         if (got.record_code !== want.record_code) begin
            $error("record_code: expected %h, actual %h", want.record_code, got.record_code);
            failures++;
         end
         if (got.record_time !== want.record_time) begin
            $error("record_time: expected %h, actual %h", want.record_time, got.record_time);
            failures++;
         end
         if (got.is_end_marker !== want.is_end_marker) begin
            $error("is_end_marker: expected %b, actual %b",
                   want.is_end_marker, got.is_end_marker);
            failures++;
         end
         if (got.error_total !== want.error_total) begin
            $error("error_total: expected %0d, actual %0d", want.error_total, got.error_total);
            failures++;
         end
         if (got.last_write !== want.last_write) begin
            $error("last_write: expected %b, actual %b", want.last_write, got.last_write);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tel_scoreboard board;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            quiet_cycles  = 0;
   logic [15:0]   hot_code [HOT_CODES];

   throttled_event_log_writer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_write(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_event(input logic [15:0] code, input logic [31:0] stamp);
      req_type item;
      item.event_code = code;
      item.event_time = stamp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_event(item);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic configure(input logic [15:0] start, input logic [15:0] marker,
                            input logic [7:0] limit, input logic [CAP_W-1:0] cap);
      write_reg(CSR_ERROR_CODE_START, start);
      write_reg(CSR_THROTTLE_MARKER_CODE, marker);
      write_reg(CSR_PER_CODE_LIMIT, CSR_DATA_W'(limit));
      write_reg(CSR_LOG_CAPACITY, CSR_DATA_W'(cap));
   endtask

   // Drop valid, wait out every pending write, then let a dropped event finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly repeats of the hot codes so they climb to the limit; the rest is noise.
   task automatic run_phase(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 75) begin
            send_event(hot_code[$urandom_range(0, HOT_CODES - 1)], $urandom);
         end else begin
            send_event(16'($urandom), $urandom);
         end
      end
      settle();
   endtask

   initial begin
      board = new();
      for (int i = 0; i < HOT_CODES; i++) hot_code[i] = {3'(i), 13'($urandom)};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of both fields under the reset settings
      send_event(16'h0000, 32'h0000_0000);
      send_event(16'hFFFF, 32'hFFFF_FFFF);
      send_event(16'h8000, 32'h1234_5678);
      send_event(16'h7FFF, 32'h8000_0000);
      send_event(16'hAAAA, 32'h5555_5555);
      send_event(16'h5555, 32'hAAAA_AAAA);
      settle();

      // one-slot ring, marker code equal to the end code, limit of two
      configure(16'h0000, 16'hFFFF, 8'd2, 11'd1);
      repeat (3) send_event(16'h0100, $urandom);
      settle();

      // limit zero drops every repeat; capacity zero acts as one
      configure(16'h0000, 16'h0000, 8'd0, 11'd0);
      repeat (2) send_event(16'h0200, $urandom);
      send_event(16'h0100, $urandom);
      settle();

      // oversized capacity, top error threshold, limit of one
      configure(16'hFFFF, 16'($urandom), 8'd1, 11'd2047);
      repeat (2) send_event(16'h0300, $urandom);
      send_event(16'hFFFF, $urandom);
      settle();

      send_idle_pct = 6;
      recv_idle_pct = 58;
      configure(16'($urandom), 16'($urandom), 8'd3, 11'd1024);
      run_phase(55);
      configure(16'h0000, 16'hFFFF, 8'd8, 11'd7);
      run_phase(55);

      send_idle_pct = 58;
      recv_idle_pct = 6;
      configure(16'hFFFF, 16'($urandom), 8'd14, 11'd1);
      run_phase(55);
      configure(16'h8000, 16'h0000, 8'd20, 11'd0);
      run_phase(55);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(16'($urandom), 16'($urandom), 8'd25, 11'd2047);
      run_phase(55);
      configure(16'($urandom), 16'($urandom), 8'($urandom_range(26, 40)), 11'd1024);
      run_phase(55);

      // hammer one code past its limit so the repeats beyond it drop
      configure(16'($urandom), 16'($urandom), 8'd40, 11'd3);
      repeat (30) send_event(hot_code[0], $urandom);
      send_event(16'($urandom), $urandom);
      settle();

      $display("Covered %0d events: %0d slot writes checked, %0d throttle markers, %0d drops",
               board.events_noted, board.writes_checked, board.markers_predicted,
               board.events_dropped);
      if (board.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/tel_pkg.sv
rtl/core/tel_dpath.sv
rtl/core/tel_ctrl.sv
rtl/core/throttled_event_log_writer.sv
sim/tb_top.sv
